// ===== rtl/core/tspcmr_pkg.sv =====
// Shared widths and constants for the cost matrix reduction block.
`timescale 1ns / 1ps

package tspcmr_pkg;

  localparam int COST_W = 31;
  localparam int SUM_W  = 36;
  localparam int TOT_W  = 35;
  localparam int NU_W   = 4;

  localparam logic [COST_W-1:0] BLOCKED  = 31'h7FFF_FFFF;
  localparam logic [NU_W-1:0]   NU_RESET = 4'd8;

endpackage

// ===== rtl/core/tspcmr_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
`timescale 1ns / 1ps

module tspcmr_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/tsp_cost_matrix_reduction_top.sv =====
// Top level: loads a cost matrix, reduces its rows and columns, and emits it.
//
//   Channel   Signals                                      Direction
//   -------   -------------------------------------------  ---------
//   command   start, busy, cost                            in (busy out)
//   result    result_valid, reduced_cost,                  out
//             lower_bound, last
//   config    cfg_we, cfg_wdata                            in
//
// Each cost word loads while the block is idle. After the final word of an n by n matrix,
// busy stays high while each of the 2n lines takes a minimum scan and a subtract scan
// through the one RAM read port, and while the n*n result words are read out one per
// cycle.
// Reset is synchronous and returns the side to 8 with an empty matrix.
// The receiver cannot stall; each result word shows for exactly one cycle.
`timescale 1ns / 1ps

module tsp_cost_matrix_reduction_top
  import tspcmr_pkg::*;
#(
  parameter int MAX_CITIES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [COST_W-1:0] cost,
  input  logic              cfg_we,
  input  logic [NU_W-1:0]   cfg_wdata,
  output logic              result_valid,
  output logic [COST_W-1:0] reduced_cost,
  output logic [TOT_W-1:0]  lower_bound,
  output logic              last
);

  localparam int DEPTH = MAX_CITIES * MAX_CITIES;
  localparam int AW    = $clog2(DEPTH);
  localparam int CW    = $clog2(DEPTH + 1);
  localparam int NW    = $clog2(MAX_CITIES + 1);
  localparam int LW    = $clog2(MAX_CITIES);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MIN,
    S_MIN_END,
    S_SUB,
    S_SUB_END,
    S_EMIT,
    S_EMIT_END
  } state_t;

  state_t            state;
  logic [NU_W-1:0]   n_used;
  logic [CW-1:0]     count;
  logic [LW-1:0]     line;
  logic [LW-1:0]     k;
  logic              col_pass;
  logic [AW-1:0]     pos;
  logic [COST_W-1:0] mn;
  logic [SUM_W-1:0]  sum;
  logic              rd_min;
  logic              rd_sub;
  logic              rd_emit;
  logic              rd_last;
  logic [AW-1:0]     rd_addr;

  logic [NW-1:0]     n;
  logic [CW-1:0]     total;
  logic [CW-1:0]     count_next;
  logic              line_last;
  logic              k_last;
  logic              pos_last;
  logic [LW-1:0]     r_sel;
  logic [LW-1:0]     c_sel;
  logic [AW-1:0]     line_addr;
  logic [AW-1:0]     raddr;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [COST_W-1:0] wdata;
  logic [COST_W-1:0] rdata;
  logic [COST_W-1:0] min_now;
  logic [COST_W-1:0] min_eff;

  always_comb begin
    if (n_used == '0) begin
      n = NW'(1);
    end else if (n_used > NU_W'(MAX_CITIES)) begin
      n = NW'(MAX_CITIES);
    end else begin
      n = NW'(n_used);
    end
  end

  assign total      = CW'(CW'(n) * CW'(n));
  assign count_next = count + CW'(1);
  assign line_last  = (NW'(line) == n - NW'(1));
  assign k_last     = (NW'(k) == n - NW'(1));
  assign pos_last   = (CW'(pos) == total - CW'(1));
  assign r_sel      = col_pass ? k : line;
  assign c_sel      = col_pass ? line : k;
  assign line_addr  = AW'(CW'(r_sel) * CW'(n) + CW'(c_sel));
  assign raddr      = (state == S_EMIT) ? pos : line_addr;

  assign we    = (state == S_IDLE && start) || rd_sub;
  assign waddr = rd_sub ? rd_addr : count[AW-1:0];
  assign wdata = rd_sub ? ((rdata == BLOCKED) ? rdata : rdata - mn) : cost;

  assign min_now = (rd_min && rdata < mn) ? rdata : mn;
  assign min_eff = (min_now == BLOCKED) ? '0 : min_now;

  assign busy        = (state != S_IDLE);
  assign lower_bound = sum[TOT_W-1:0];

  tspcmr_ram #(
    .WIDTH (COST_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      n_used       <= NU_RESET;
      count        <= '0;
      line         <= '0;
      k            <= '0;
      col_pass     <= 1'b0;
      pos          <= '0;
      sum          <= '0;
      rd_min       <= 1'b0;
      rd_sub       <= 1'b0;
      rd_emit      <= 1'b0;
      rd_last      <= 1'b0;
      result_valid <= 1'b0;
      last         <= 1'b0;
    end else begin
      if (cfg_we) begin
        n_used <= cfg_wdata;
      end
      rd_min       <= (state == S_MIN);
      rd_sub       <= (state == S_SUB);
      rd_emit      <= (state == S_EMIT);
      rd_last      <= (state == S_EMIT) && pos_last;
      rd_addr      <= raddr;
      result_valid <= rd_emit;
      last         <= rd_emit && rd_last;
      if (rd_emit) begin
        reduced_cost <= rdata;
      end
      unique case (state)
        S_IDLE: begin
          if (start) begin
            if (count_next >= total) begin
              count    <= '0;
              line     <= '0;
              k        <= '0;
              col_pass <= 1'b0;
              mn       <= BLOCKED;
              sum      <= '0;
              state    <= S_MIN;
            end else begin
              count <= count_next;
            end
          end
        end
        S_MIN: begin
          if (rd_min) begin
            mn <= min_now;
          end
          if (k_last) begin
            k     <= '0;
            state <= S_MIN_END;
          end else begin
            k <= k + LW'(1);
          end
        end
        S_MIN_END: begin
          mn    <= min_eff;
          sum   <= sum + SUM_W'(min_eff);
          state <= S_SUB;
        end
        S_SUB: begin
          if (k_last) begin
            k     <= '0;
            state <= S_SUB_END;
          end else begin
            k <= k + LW'(1);
          end
        end
        S_SUB_END: begin
          mn <= BLOCKED;
          if (line_last) begin
            line <= '0;
            if (col_pass) begin
              pos   <= '0;
              state <= S_EMIT;
            end else begin
              col_pass <= 1'b1;
              state    <= S_MIN;
            end
          end else begin
            line  <= line + LW'(1);
            state <= S_MIN;
          end
        end
        S_EMIT: begin
          pos <= pos + AW'(1);
          if (pos_last) begin
            state <= S_EMIT_END;
          end
        end
        S_EMIT_END: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== rtl/core/tspcmr_checker.sv =====
// Port-level checks for the cost matrix reduction block and their binding.
`timescale 1ns / 1ps

module tspcmr_checker
  import tspcmr_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             result_valid,
  input logic             last,
  input logic [TOT_W-1:0] lower_bound
);

  // Result words appear only during a busy period or in the cycle right after it.
  a_result_in_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (busy || $past(busy)))
    else $error("result word outside a busy period");

  a_last_marked: assert property (@(posedge clk) disable iff (rst)
    last |-> result_valid)
    else $error("last flag without a result word");

  a_last_ends: assert property (@(posedge clk) disable iff (rst)
    (result_valid && last) |=> !result_valid)
    else $error("result word after the last word of a matrix");

  a_busy_from_start: assert property (@(posedge clk) disable iff (rst)
    $rose(busy) |-> $past(start))
    else $error("busy rose without an accepted word");

  a_total_steady: assert property (@(posedge clk) disable iff (rst)
    (result_valid && $past(result_valid)) |-> $stable(lower_bound))
    else $error("total reduction changed within one matrix");

endmodule

bind tsp_cost_matrix_reduction_top tspcmr_checker u_tspcmr_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .last         (last),
  .lower_bound  (lower_bound)
);

// ===== tb/tsp_cost_matrix_reduction_checker.sv =====
// Checker that predicts and compares the reduced cost matrix words of the block.
`timescale 1ns / 1ps

module tsp_cost_matrix_reduction_checker
  import tspcmr_pkg::*;
#(
  parameter int MAX_CITIES = 8
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic              busy,
  input  logic [COST_W-1:0] cost,
  input  logic              cfg_we,
  input  logic [NU_W-1:0]   cfg_wdata,
  input  logic              result_valid,
  input  logic [COST_W-1:0] reduced_cost,
  input  logic [TOT_W-1:0]  lower_bound,
  input  logic              last,
  output int                errors,
  output int                pending,
  output int                words_seen,
  output int                matrices_seen
);

  typedef struct packed {
    logic [COST_W-1:0] cost;
    logic [TOT_W-1:0]  total;
    logic              last;
  } reduced_word_t;

  reduced_word_t     reduced_q[$];
  logic [COST_W-1:0] cost_ram[64];
  logic [6:0]        load_count;
  logic [NU_W-1:0]   side_reg;

  initial begin
    errors        = 0;
    pending       = 0;
    words_seen    = 0;
    matrices_seen = 0;
  end

  function automatic int unsigned side_of(logic [NU_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_CITIES) return MAX_CITIES;
    return int'(v);
  endfunction

  // Subtracts the minimum of one row or column from its open entries.
  function automatic logic [COST_W-1:0] reduce_line(int unsigned base, int unsigned stride,
                                                    int unsigned len);
    logic [COST_W-1:0] line_min;
    int unsigned       idx;
    int unsigned       k;
    line_min = BLOCKED;
    for (k = 0; k < len; k++) begin
      idx = (base + k * stride) % 64;
      if (cost_ram[idx] < line_min) line_min = cost_ram[idx];
    end
    if (line_min == BLOCKED) line_min = '0;
    for (k = 0; k < len; k++) begin
      idx = (base + k * stride) % 64;
      if (cost_ram[idx] != BLOCKED) cost_ram[idx] = cost_ram[idx] - line_min;
    end
    return line_min;
  endfunction

  task automatic load_cost_word(logic [COST_W-1:0] c);
    int unsigned       n;
    int unsigned       area;
    int unsigned       i;
    logic [SUM_W-1:0]  sum;
    reduced_word_t     w;
    n    = side_of(side_reg);
    area = n * n;
    cost_ram[load_count[5:0]] = c;
    load_count = load_count + 7'd1;
    if (int'(load_count) < area) return;
    sum = '0;
    for (i = 0; i < n; i++) sum = sum + SUM_W'(reduce_line(i * n, 1, n));
    for (i = 0; i < n; i++) sum = sum + SUM_W'(reduce_line(i, n, n));
    for (i = 0; i < area; i++) begin
      w.cost  = cost_ram[i % 64];
      w.total = sum[TOT_W-1:0];
      w.last  = (i + 1 == area);
      reduced_q.push_back(w);
    end
    load_count = '0;
    matrices_seen++;
  endtask

  task automatic report_mismatch(string msg);
    $display("[%0t] MISMATCH: %s", $realtime, msg);
    errors++;
  endtask

  task automatic check_word();
    reduced_word_t want;
    words_seen++;
    if (reduced_q.size() == 0) begin
      report_mismatch($sformatf("unexpected word: cost %0d total %0d last %0b",
                                reduced_cost, lower_bound, last));
      return;
    end
    want = reduced_q.pop_front();
    if (reduced_cost !== want.cost)
      report_mismatch($sformatf("reduced_cost got %0d expected %0d", reduced_cost, want.cost));
    if (lower_bound !== want.total)
      report_mismatch($sformatf("lower_bound got %0d expected %0d",
                                lower_bound, want.total));
    if (last !== want.last)
      report_mismatch($sformatf("last got %0b expected %0b", last, want.last));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      reduced_q.delete();
      load_count = '0;
      side_reg   = NU_RESET;
    end else begin
      if (result_valid === 1'b1) check_word();
      if (cfg_we) side_reg = cfg_wdata;
      if (start && !busy) load_cost_word(cost);
    end
    pending <= reduced_q.size();
  end

endmodule

// ===== tb/tsp_cost_matrix_reduction_top_tb.sv =====
// Testbench top: drives cost words and side settings and gives the verdict.
`timescale 1ns / 1ps

module tsp_cost_matrix_reduction_top_tb;
  import tspcmr_pkg::*;

  localparam int MAX_CITIES    = 8;
  localparam int TARGET_WORDS  = 170;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES   = 20;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              start     = 1'b0;
  logic [COST_W-1:0] cost      = '0;
  logic              cfg_we    = 1'b0;
  logic [NU_W-1:0]   cfg_wdata = '0;
  logic              busy;
  logic              result_valid;
  logic [COST_W-1:0] reduced_cost;
  logic [TOT_W-1:0]  lower_bound;
  logic              last;

  int errors;
  int pending;
  int words_seen;
  int matrices_seen;
  int words_sent = 0;
  int loaded     = 0;
  bit no_idle    = 1'b0;

  tsp_cost_matrix_reduction_top #(.MAX_CITIES(MAX_CITIES)) uut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .cost         (cost),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .result_valid (result_valid),
    .reduced_cost (reduced_cost),
    .lower_bound  (lower_bound),
    .last         (last)
  );

  tsp_cost_matrix_reduction_checker #(.MAX_CITIES(MAX_CITIES)) u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .cost          (cost),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .result_valid  (result_valid),
    .reduced_cost  (reduced_cost),
    .lower_bound   (lower_bound),
    .last          (last),
    .errors        (errors),
    .pending       (pending),
    .words_seen    (words_seen),
    .matrices_seen (matrices_seen)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #20ms;
    $display("tsp_cost_matrix_reduction_top verification failed");
    $finish;
  end

  function automatic int unsigned side_of(logic [NU_W-1:0] v);
    if (v == '0) return 1;
    if (int'(v) > MAX_CITIES) return MAX_CITIES;
    return int'(v);
  endfunction

  function automatic logic [COST_W-1:0] pick_cost(int unsigned block_pct);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < block_pct) return BLOCKED;
    r = $urandom_range(0, 9);
    if (r < 4) return COST_W'($urandom_range(0, 200));
    if (r < 6) return BLOCKED - COST_W'($urandom_range(1, 50));
    return COST_W'($urandom);
  endfunction

  task automatic idle_gap();
    int unsigned r;
    int unsigned gap;
    if (no_idle) return;
    r = $urandom_range(0, 99);
    if (r < 55) gap = 0;
    else if (r < 90) gap = $urandom_range(1, 3);
    else gap = $urandom_range(8, 40);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic send_word(logic [COST_W-1:0] c);
    start <= 1'b1;
    cost  <= c;
    do @(posedge clk); while (busy);
    words_sent++;
    loaded++;
    idle_gap();
  endtask

  task automatic drain_results();
    start <= 1'b0;
    do @(posedge clk); while (busy || pending != 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_side(logic [NU_W-1:0] v);
    drain_results();
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [NU_W-1:0] pick_side();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r == 0) return '0;
    if (r == 1) return NU_W'($urandom_range(MAX_CITIES + 1, 15));
    if (r == 2) return NU_W'(MAX_CITIES);
    if (r < 6) return NU_W'($urandom_range(6, 7));
    return NU_W'($urandom_range(1, 5));
  endfunction

  initial begin
    logic [NU_W-1:0] side_val;
    int unsigned     area;
    int unsigned     block_pct;
    int unsigned     k;
    int unsigned     remaining;

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Single-city matrices, the smallest cost and a blocked one.
    write_side(4'd1);
    send_word('0);
    send_word(BLOCKED);

    // A fully blocked row beside a nearly blocked entry.
    write_side(4'd2);
    send_word(BLOCKED);
    send_word(BLOCKED);
    send_word(BLOCKED - 31'd1);
    send_word(31'd5);

    // A fully blocked column with large costs in the other lines.
    write_side(4'd3);
    send_word(31'd7);
    send_word(31'd3);
    send_word(BLOCKED);
    send_word(BLOCKED - 31'd1);
    send_word(BLOCKED - 31'd2);
    send_word(BLOCKED);
    send_word('0);
    send_word(31'd9);
    send_word(BLOCKED);

    // The side shrinks after more words than the new matrix holds.
    loaded = 0;
    for (k = 0; k < 5; k++) send_word(pick_cost(20));
    write_side(4'd2);
    send_word(pick_cost(20));

    // A side of zero acts as one city.
    write_side(4'd0);
    send_word(COST_W'($urandom));

    write_side(4'd15);
    side_val = 4'd15;
    while (words_sent < TARGET_WORDS) begin
      if ($urandom_range(0, 1) == 0) begin
        side_val = pick_side();
        write_side(side_val);
      end else if ($urandom_range(0, 5) == 0) begin
        drain_results();
      end
      no_idle   = ($urandom_range(0, 3) == 0);
      block_pct = $urandom_range(0, 3) * 20;
      area      = side_of(side_val) * side_of(side_val);
      loaded    = 0;
      remaining = area;
      if (area > 1 && $urandom_range(0, 7) == 0) begin
        k = $urandom_range(1, area - 1);
        repeat (k) send_word(pick_cost(block_pct));
        side_val = pick_side();
        write_side(side_val);
        area      = side_of(side_val) * side_of(side_val);
        remaining = (area > loaded) ? area - loaded : 1;
      end
      repeat (remaining) send_word(pick_cost(block_pct));
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Summary: %0d cost words loaded into %0d matrices, %0d reduced words compared.",
             words_sent, matrices_seen, words_seen);
    $display("Sides 1 to 8 with out-of-range settings, blocked lines and mid-load side changes.");
    if (errors == 0 && pending == 0) begin
      $display("tsp_cost_matrix_reduction_top verification clean");
    end else begin
      $display("tsp_cost_matrix_reduction_top verification failed");
    end
    $finish;
  end

endmodule
